[src/spg_pkg.sv]
// Shared types and constants for the single-edge PWM generator.
package spg_pkg;

  localparam int unsigned KindW    = 3;
  localparam int unsigned FreqW    = 31;
  localparam int unsigned PctInW   = 8;
  localparam int unsigned PctW     = 7;
  localparam int unsigned ClockW   = 28;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned DivdW = ClockW;
  localparam int unsigned DivsW = 31;
  localparam int unsigned DivCntW = 6;

  localparam int unsigned QuoW      = 22;
  localparam int unsigned RecW      = 27;
  localparam int unsigned RecShift  = 31;
  localparam int unsigned RecProdW  = ClockW - 2 + RecW;
  localparam int unsigned AmulW     = QuoW + PctW;
  localparam int unsigned FracW     = 2 * PctW;
  localparam int unsigned FracRecW  = 13;
  localparam int unsigned FracShift = 17;
  localparam int unsigned FracProdW = FracW - 2 + FracRecW;

  localparam logic [KindW-1:0] KIND_TICK  = 3'd0;
  localparam logic [KindW-1:0] KIND_FREQ  = 3'd1;
  localparam logic [KindW-1:0] KIND_DUTY  = 3'd2;
  localparam logic [KindW-1:0] KIND_START = 3'd3;
  localparam logic [KindW-1:0] KIND_STOP  = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_CLOCK_HZ  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PRESCALE  = 1'b1;

  localparam logic [ClockW-1:0]  CLOCK_HZ_RST   = 28'd60000000;
  localparam logic [CountW-1:0]  PRESCALE_RST   = 32'd1;
  localparam logic [CountW-1:0]  PERIOD_RST     = 32'd3000;
  localparam logic [FreqW-1:0]   FREQ_RST       = 31'd20000;
  localparam logic [PctW-1:0]    PCT_RST        = 7'd50;
  localparam logic [PctInW-1:0]  PCT_MAX        = 8'd100;
  localparam logic [ClockW-1:0]  PCT_DIVISOR    = 28'd100;

  // Reciprocals of 25 for dividing a quarter of the operand by 25.
  localparam logic [RecW-1:0]     RECIP_25      = 27'd85899346;
  localparam logic [FracRecW-1:0] FRAC_RECIP_25 = 13'd5243;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_FREQ  = 3'd1,
    OP_DUTY  = 3'd2,
    OP_START = 3'd3,
    OP_STOP  = 3'd4,
    OP_BAD   = 3'd5
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             reject;
    logic [FreqW-1:0] freq;
    logic [PctW-1:0]  pct;
  } spg_cmd_t;

  typedef struct packed {
    logic [ClockW-1:0] clock_hz;
    logic [CountW-1:0] prescale;
  } spg_cfg_t;

endpackage

[src/spg_if.sv]
// Handshake channel interfaces for items, results and configuration writes.
interface spg_in_if;
  import spg_pkg::*;
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [FreqW-1:0]   frequency_hz;
  logic [PctInW-1:0]  duty_percent;
  modport source (output valid, kind, frequency_hz, duty_percent, input ready);
  modport sink   (input valid, kind, frequency_hz, duty_percent, output ready);
endinterface

interface spg_out_if;
  import spg_pkg::*;
  logic              valid;
  logic              ready;
  logic              pwm_level;
  logic              status;
  logic [CountW-1:0] timer_count;
  modport source (output valid, pwm_level, status, timer_count, input ready);
  modport sink   (input valid, pwm_level, status, timer_count, output ready);
endinterface

interface spg_cfg_if;
  import spg_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/single_edge_pwm_generator_top.sv]
// A tick, start, stop or rejected request finishes in the idle state; its result is registered.
// An accepted frequency or duty request starts the serial divider for clock over frequency,
// waits in ST_DIV_PER for the quotient, then scales it in ST_RECIP, ST_SPLIT, ST_FRAC, ST_FINISH.
// Throughput: one tick per cycle; the back stalls for those requests and while a result waits,
// and the two-entry queue holds items meanwhile.
// Reset: asynchronous, active low; clears the timer, queue and result valid; clock set to 60 MHz.
module single_edge_pwm_generator_top import spg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  spg_in_if.sink    in_i,
  spg_out_if.source out_o,
  spg_cfg_if.sink   cfg_i
);

  spg_cfg_t cfg_q;
  logic     push, full, pop, head_valid;
  spg_cmd_t push_cmd, head_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_hz <= CLOCK_HZ_RST;
      cfg_q.prescale <= PRESCALE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CLOCK_HZ: cfg_q.clock_hz <= cfg_i.data[ClockW-1:0];
        CFG_PRESCALE: cfg_q.prescale <= cfg_i.data;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  spg_front u_front (
    .in_i       (in_i),
    .clock_hz_i (cfg_q.clock_hz),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  spg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head_cmd)
  );

  spg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

[src/spg_div.sv]
// Restoring serial divider that produces one quotient bit per cycle.
module spg_div import spg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivdW-1:0] dividend_i,
  input  logic [DivsW-1:0] divisor_i,
  output logic             done_o,
  output logic [DivdW-1:0] quotient_o
);

  logic [DivdW-1:0]   dq_q, dq_d;
  logic [DivsW:0]     rem_q, rem_d;
  logic [DivsW-1:0]   dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivsW:0]     rem_sh;

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[DivsW-1:0], dq_q[DivdW-1]};
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = DivCntW'(DivdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        dq_d  = {dq_q[DivdW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        dq_d  = {dq_q[DivdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

[src/spg_queue.sv]
// Two-entry command queue between the front and the back.
module spg_queue import spg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  spg_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output spg_cmd_t head_o
);

  spg_cmd_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

endmodule

[src/spg_front.sv]
// Front end: accepts items, decodes the kind and checks request ranges.
module spg_front import spg_pkg::*; (
  spg_in_if.sink            in_i,
  input  logic [ClockW-1:0] clock_hz_i,
  input  logic              full_i,
  output logic              push_o,
  output spg_cmd_t          cmd_o
);

  always_comb begin
    cmd_o.freq   = in_i.frequency_hz;
    cmd_o.pct    = in_i.duty_percent[PctW-1:0];
    cmd_o.reject = 1'b0;
    case (in_i.kind)
      KIND_TICK:  cmd_o.op = OP_TICK;
      KIND_FREQ: begin
        cmd_o.op     = OP_FREQ;
        cmd_o.reject = (in_i.frequency_hz == '0) ||
                       (in_i.frequency_hz >= FreqW'(clock_hz_i));
      end
      KIND_DUTY: begin
        cmd_o.op     = OP_DUTY;
        cmd_o.reject = in_i.duty_percent > PCT_MAX;
      end
      KIND_START: cmd_o.op = OP_START;
      KIND_STOP:  cmd_o.op = OP_STOP;
      default: begin
        cmd_o.op     = OP_BAD;
        cmd_o.reject = 1'b1;
      end
    endcase
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

endmodule

[src/spg_back.sv]
// Back end: runs the timer, computes match values and registers results.
module spg_back import spg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spg_cfg_t cfg_i,
  input  logic     cmd_valid_i,
  input  spg_cmd_t cmd_i,
  output logic     pop_o,
  spg_out_if.source out_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIV_PER = 6'b000010,
    ST_RECIP   = 6'b000100,
    ST_SPLIT   = 6'b001000,
    ST_FRAC    = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] pc_q, pc_d, tc_q, tc_d;
  logic [CountW-1:0] pm_q, pm_d, dm_q, dm_d, ps_q, ps_d, ds_q, ds_d;
  logic [1:0]        lp_q, lp_d;
  logic [FreqW-1:0]  sf_q, sf_d;
  logic [PctW-1:0]   sp_q, sp_d;
  logic              run_q, run_d;
  logic [ClockW-1:0] per_q, per_d;
  logic [QuoW-1:0]   hq_q, hq_d;
  logic [PctW-1:0]   hr_q, hr_d;
  logic [AmulW-1:0]  ap_q, ap_d;
  logic [FracW-1:0]  fp_q, fp_d;
  logic              ov_q, ov_d, pwm_q, pwm_d, st_q, st_d;
  logic [CountW-1:0] cnt_out_q, cnt_out_d;

  logic                 slot_free, fin, status;
  logic                 div_start, div_done;
  logic [DivdW-1:0]     div_dividend, div_quo;
  logic [DivsW-1:0]     div_divisor;
  logic [PctW-1:0]      pct_sel;
  logic [CountW-1:0]    top;
  logic [RecProdW-1:0]  rec_prod;
  logic [ClockW-1:0]    hund;
  logic [FracProdW-1:0] frac_prod;

  spg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign slot_free = !ov_q || out_o.ready;
  assign pct_sel   = (cmd_i.op == OP_FREQ) ? sp_q : cmd_i.pct;

  // The duty match is (period / 100) * percent plus (period mod 100) * percent / 100.
  assign rec_prod  = RecProdW'(per_q[ClockW-1:2]) * RecProdW'(RECIP_25);
  assign hund      = ClockW'(hq_q) * PCT_DIVISOR;
  assign frac_prod = FracProdW'(fp_q[FracW-1:2]) * FracProdW'(FRAC_RECIP_25);

  always_comb begin
    state_d = state_q;
    pc_d = pc_q; tc_d = tc_q; pm_d = pm_q; dm_d = dm_q;
    ps_d = ps_q; ds_d = ds_q; lp_d = lp_q;
    sf_d = sf_q; sp_d = sp_q; run_d = run_q; per_d = per_q;
    hq_d = hq_q; hr_d = hr_q; ap_d = ap_q; fp_d = fp_q;
    fin = 1'b0;
    status = 1'b0;
    div_start = 1'b0;
    div_dividend = cfg_i.clock_hz;
    div_divisor = (cmd_i.op == OP_FREQ) ? cmd_i.freq : sf_q;
    top = cfg_i.prescale - 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          case (cmd_i.op)
            OP_TICK: begin
              fin = 1'b1;
              if (run_q) begin
                if (pc_q >= top) begin
                  pc_d = '0;
                  if (tc_q >= pm_q) begin
                    tc_d = '0;
                    if (lp_q[0]) begin
                      pm_d = ps_q;
                    end
                    if (lp_q[1]) begin
                      dm_d = ds_q;
                    end
                    lp_d = '0;
                  end else begin
                    tc_d = tc_q + 1'b1;
                  end
                end else begin
                  pc_d = pc_q + 1'b1;
                end
              end
            end
            OP_FREQ, OP_DUTY: begin
              if (cmd_i.reject) begin
                fin = 1'b1;
                status = 1'b1;
              end else begin
                div_start = 1'b1;
                state_d = ST_DIV_PER;
              end
            end
            OP_START: begin
              fin = 1'b1;
              run_d = 1'b1;
            end
            OP_STOP: begin
              fin = 1'b1;
              run_d = 1'b0;
              pc_d = '0;
              tc_d = '0;
            end
            default: begin
              fin = 1'b1;
              status = 1'b1;
            end
          endcase
        end
      end
      ST_DIV_PER: begin
        if (div_done) begin
          per_d = div_quo;
          state_d = ST_RECIP;
        end
      end
      ST_RECIP: begin
        hq_d = rec_prod[RecProdW-1:RecShift];
        state_d = ST_SPLIT;
      end
      ST_SPLIT: begin
        hr_d = PctW'(per_q - hund);
        ap_d = AmulW'(hq_q) * AmulW'(pct_sel);
        state_d = ST_FRAC;
      end
      ST_FRAC: begin
        fp_d = FracW'(hr_q) * FracW'(pct_sel);
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        fin = 1'b1;
        state_d = ST_IDLE;
        ds_d = CountW'(ap_q) + CountW'(frac_prod[FracProdW-1:FracShift]);
        if (cmd_i.op == OP_FREQ) begin
          sf_d = cmd_i.freq;
          ps_d = {{(CountW-ClockW){1'b0}}, per_q};
          lp_d = 2'b11;
        end else begin
          sp_d = cmd_i.pct;
          lp_d = lp_q | 2'b10;
        end
        if (!run_q) begin
          if (lp_d[0]) begin
            pm_d = ps_d;
          end
          if (lp_d[1]) begin
            dm_d = ds_d;
          end
          lp_d = '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    pwm_d = pwm_q;
    st_d = st_q;
    cnt_out_d = cnt_out_q;
    if (fin) begin
      ov_d = 1'b1;
      pwm_d = run_d && (tc_d < dm_d);
      st_d = status;
      cnt_out_d = tc_d;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q <= '0;
      tc_q <= '0;
      pm_q <= PERIOD_RST;
      dm_q <= '0;
      ps_q <= PERIOD_RST;
      ds_q <= '0;
      lp_q <= '0;
      sf_q <= FREQ_RST;
      sp_q <= PCT_RST;
      run_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      tc_q <= tc_d;
      pm_q <= pm_d;
      dm_q <= dm_d;
      ps_q <= ps_d;
      ds_q <= ds_d;
      lp_q <= lp_d;
      sf_q <= sf_d;
      sp_q <= sp_d;
      run_q <= run_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    per_q <= per_d;
    hq_q <= hq_d;
    hr_q <= hr_d;
    ap_q <= ap_d;
    fp_q <= fp_d;
    pwm_q <= pwm_d;
    st_q <= st_d;
    cnt_out_q <= cnt_out_d;
  end

  assign pop_o             = fin;
  assign out_o.valid       = ov_q;
  assign out_o.pwm_level   = pwm_q;
  assign out_o.status      = st_q;
  assign out_o.timer_count = cnt_out_q;

endmodule

[src/spg_checker.sv]
// Port-level checks for the PWM generator and their binding to the top level.
module spg_checker import spg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_pwm,
  input logic              out_status,
  input logic [CountW-1:0] out_count,
  input logic              cfg_ready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pwm) && $stable(out_status) &&
    $stable(out_count))
    else $error("Stalled result changed or was dropped.");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("Result valid right after reset.");

  a_ready_after_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> in_ready)
    else $error("Input not ready when leaving reset.");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready)
    else $error("Configuration port not ready.");

endmodule

bind single_edge_pwm_generator_top spg_checker u_spg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_pwm    (out_o.pwm_level),
  .out_status (out_o.status),
  .out_count  (out_o.timer_count),
  .cfg_ready  (cfg_i.ready)
);
